/* rtl/nap_pkg.sv */
// Shared types, constants and helper functions for the notification attribute parser.
package nap_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int OFF_W        = $clog2(BUFFER_BYTES) + 4;
    localparam int CFG_IDX_W    = 1;
    localparam int MAX_RESULTS  = 3;

    localparam logic [7:0] TITLE_LIMIT_RESET   = 8'd64;
    localparam logic [7:0] MESSAGE_LIMIT_RESET = 8'd164;

    localparam logic [CFG_IDX_W-1:0] REG_TITLE_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        PH_COMMAND = 4'd0,
        PH_ID1     = 4'd1,
        PH_ID2     = 4'd2,
        PH_ID3     = 4'd3,
        PH_ID4     = 4'd4,
        PH_ATTR_ID = 4'd5,
        PH_LEN_LO  = 4'd6,
        PH_LEN_HI  = 4'd7,
        PH_DATA    = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        KIND_WRITE     = 3'd0,
        KIND_TITLE_LEN = 3'd1,
        KIND_MSG_LEN   = 3'd2,
        KIND_DONE      = 3'd3,
        KIND_ERROR     = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] address;
        logic [7:0] value;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]                   count;
        result_t [MAX_RESULTS-1:0]    res;
    } result_set_t;

    function automatic result_t make_result(input kind_t kind, input logic [7:0] address,
                                            input logic [7:0] value);
        result_t r;
        r.kind    = kind;
        r.address = address;
        r.value   = value;
        r.last    = 1'b0;
        return r;
    endfunction

    // Reduces a buffer offset modulo the buffer size by conditional subtraction.
    function automatic logic [7:0] wrap_addr(input logic [8:0] off);
        logic [OFF_W-1:0] v;
        logic [OFF_W-1:0] step;
        v = OFF_W'(off);
        for (int k = 3; k >= 0; k--) begin
            step = OFF_W'(BUFFER_BYTES) << k;
            if (v >= step) begin
                v = v - step;
            end
        end
        return v[7:0];
    endfunction

endpackage

/* rtl/notification_attribute_parser.sv */
// Top level of the notification attribute response parser.
//
//   Port group   Direction  Contents
//   s_*          in         one response byte, new-notification flag, end of packet
//   m_*          out        buffer writes, length reports, completion, length error
//   cfg_*        in         writes of the title and message length limits
//
// A byte enters an input register, the parser turns it into zero to three results in the
// next cycle and a result buffer sends them one per cycle while m_tready is high. A byte with
// at most one result sustains one transaction per cycle; a byte with two or three results
// holds the input while the buffer drains. Reset is synchronous and active low and
// returns the limits to 64 and 164. A stall on m_tready backs up into s_tready.
module notification_attribute_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // data_byte [7:0]
    input  logic                            s_tuser,   // action [0]
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // address [7:0], value [15:8]
    output logic [2:0]                      m_tuser,   // kind [2:0]
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);
    import nap_pkg::*;

    logic        in_valid_reg;
    logic        in_action_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eop_reg;
    logic [7:0]  title_limit_reg;
    logic [7:0]  message_limit_reg;
    logic        take;
    logic        free;
    result_set_t results;

    assign cfg_ready = 1'b1;
    assign take      = in_valid_reg && ((results.count == 2'd0) || free);
    assign s_tready  = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
            in_eop_reg    <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            title_limit_reg   <= TITLE_LIMIT_RESET;
            message_limit_reg <= MESSAGE_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TITLE_LIMIT:   title_limit_reg   <= cfg_data;
                REG_MESSAGE_LIMIT: message_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    nap_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (take),
        .in_action     (in_action_reg),
        .in_byte       (in_byte_reg),
        .in_eop        (in_eop_reg),
        .title_limit   (title_limit_reg),
        .message_limit (message_limit_reg),
        .results       (results)
    );

    nap_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && (results.count != 2'd0)),
        .results  (results),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/nap_parser.sv */
// Parse state machine that turns one response byte into up to three results.
module nap_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  logic                 in_action,
    input  logic [7:0]           in_byte,
    input  logic                 in_eop,
    input  logic [7:0]           title_limit,
    input  logic [7:0]           message_limit,
    output nap_pkg::result_set_t results
);
    import nap_pkg::*;

    phase_t     phase_reg, phase_next;
    logic       sel_reg, sel_next;
    logic       skip_reg, skip_next;
    logic [7:0] cur_len_reg, cur_len_next;
    logic [7:0] rcvd_reg, rcvd_next;
    logic [7:0] tsize_reg, tsize_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_COMMAND;
            sel_reg     <= 1'b0;
            skip_reg    <= 1'b0;
            cur_len_reg <= '0;
            rcvd_reg    <= '0;
            tsize_reg   <= '0;
        end else if (take) begin
            phase_reg   <= phase_next;
            sel_reg     <= sel_next;
            skip_reg    <= skip_next;
            cur_len_reg <= cur_len_next;
            rcvd_reg    <= rcvd_next;
            tsize_reg   <= tsize_next;
        end
    end

    always_comb begin
        logic [1:0] n;
        logic [7:0] base;
        logic [7:0] limit;
        logic       over;
        logic       finish;
        logic [7:0] fin_len;
        logic [7:0] rcvd_inc;

        phase_next   = phase_reg;
        sel_next     = sel_reg;
        skip_next    = skip_reg;
        cur_len_next = cur_len_reg;
        rcvd_next    = rcvd_reg;
        tsize_next   = tsize_reg;
        results      = '0;
        n            = 2'd0;
        base         = sel_reg ? tsize_reg : 8'd0;
        limit        = sel_reg ? message_limit : title_limit;
        over         = (in_byte != 8'd0) || (cur_len_reg > limit);
        finish       = 1'b0;
        fin_len      = cur_len_reg;
        rcvd_inc     = rcvd_reg + 8'd1;

        if (in_action) begin
            sel_next = 1'b0;
        end else if (skip_reg) begin
            if (in_eop) begin
                skip_next = 1'b0;
            end
        end else begin
            unique case (phase_reg)
                PH_ID1:     phase_next = PH_ID2;
                PH_ID2:     phase_next = PH_ID3;
                PH_ID3:     phase_next = PH_ID4;
                PH_ID4:     phase_next = PH_ATTR_ID;
                PH_ATTR_ID: phase_next = PH_LEN_LO;
                PH_LEN_LO: begin
                    cur_len_next = in_byte;
                    phase_next   = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    if (over) begin
                        results.res[n] = make_result(KIND_ERROR, 8'd0,
                                                     (in_byte != 8'd0) ? 8'hFF : cur_len_reg);
                        n          = n + 2'd1;
                        phase_next = PH_COMMAND;
                        sel_next   = 1'b0;
                        skip_next  = !in_eop;
                    end else begin
                        if (!sel_reg) begin
                            tsize_next     = cur_len_reg;
                            results.res[n] = make_result(KIND_TITLE_LEN, 8'd0, cur_len_reg);
                        end else begin
                            results.res[n] = make_result(KIND_MSG_LEN, 8'd0, cur_len_reg);
                        end
                        n         = n + 2'd1;
                        rcvd_next = 8'd0;
                        if (cur_len_reg == 8'd0) begin
                            finish = 1'b1;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    results.res[n] = make_result(KIND_WRITE,
                                                 wrap_addr({1'b0, base} + {1'b0, rcvd_reg}),
                                                 in_byte);
                    n         = n + 2'd1;
                    rcvd_next = rcvd_inc;
                    if (rcvd_inc == cur_len_reg) begin
                        finish = 1'b1;
                    end
                end
                default: phase_next = PH_ID1;
            endcase

            if (finish) begin
                results.res[n] = make_result(KIND_WRITE,
                                             wrap_addr({1'b0, base} + {1'b0, fin_len}), 8'd0);
                n = n + 2'd1;
                if (!sel_reg) begin
                    sel_next   = 1'b1;
                    phase_next = PH_ATTR_ID;
                end else begin
                    results.res[n] = make_result(KIND_DONE, 8'd0, 8'd0);
                    n          = n + 2'd1;
                    phase_next = PH_COMMAND;
                    sel_next   = 1'b0;
                    skip_next  = !in_eop;
                end
            end
        end

        if (n != 2'd0) begin
            results.res[n - 2'd1].last = 1'b1;
        end
        results.count = n;
    end

endmodule

/* rtl/nap_out_buf.sv */
// Result buffer that holds the results of one transaction and sends them one per cycle while m_tready is high.
module nap_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  nap_pkg::result_set_t results,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // address [7:0], value [15:8]
    output logic [2:0]           m_tuser,   // kind [2:0]
    output logic                 m_tlast
);
    import nap_pkg::*;

    result_t [MAX_RESULTS-1:0] ent_reg, ent_next;
    logic [1:0]                cnt_reg, cnt_next;
    logic                      pop;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign free     = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);

    always_comb begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (load) begin
            ent_next = results.res;
            cnt_next = results.count;
        end else if (pop) begin
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign m_tdata = {ent_reg[0].value, ent_reg[0].address};
    assign m_tuser = ent_reg[0].kind;
    assign m_tlast = ent_reg[0].last;

endmodule

/* dv/tb_notification_attribute_parser.sv */
// Self-checking testbench for the notification attribute parser with a built-in response predictor.
module tb_notification_attribute_parser;
    import nap_pkg::*;

    typedef struct {
        bit       act;
        bit [7:0] data;
        bit       eop;
    } in_item_t;

    typedef struct {
        kind_t    kind;
        bit [7:0] addr;
        bit [7:0] value;
        bit       last;
    } exp_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'd0;
    logic                 s_tuser   = 1'b0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = 8'd0;

    in_item_t    pending_bytes[$];
    exp_result_t expected_results[$];
    exp_result_t step_results[$];

    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    int pushed      = 0;
    int err_count   = 0;
    int results_seen = 0;

    phase_t   parse_ph  = PH_COMMAND;
    bit       sel_msg   = 1'b0;
    bit [15:0] cur_len  = 16'd0;
    bit [15:0] rcvd     = 16'd0;
    bit [7:0] tsize     = 8'd0;
    bit       skipping  = 1'b0;
    bit [7:0] title_lim = TITLE_LIMIT_RESET;
    bit [7:0] msg_lim   = MESSAGE_LIMIT_RESET;

    notification_attribute_parser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 50) begin
            $display("mismatch in result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
        end
        err_count++;
    endtask

    task automatic add_result(input kind_t k, input int off, input bit [7:0] v);
        exp_result_t r;
        r.kind  = k;
        r.addr  = (k == KIND_WRITE) ? 8'(off % BUFFER_BYTES) : 8'd0;
        r.value = v;
        r.last  = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic restart_parse(input bit eop);
        parse_ph = PH_COMMAND;
        sel_msg  = 1'b0;
        skipping = !eop;
    endtask

    // Terminator write, then move on to the message or report completion.
    task automatic close_attribute(input bit eop);
        add_result(KIND_WRITE, (sel_msg ? int'(tsize) : 0) + int'(cur_len), 8'd0);
        if (!sel_msg) begin
            sel_msg  = 1'b1;
            parse_ph = PH_ATTR_ID;
        end else begin
            add_result(KIND_DONE, 0, 8'd0);
            restart_parse(eop);
        end
    endtask

    task automatic predict_byte(input bit act, input bit [7:0] b, input bit eop);
        bit [7:0] lim;
        step_results.delete();
        if (act) begin
            sel_msg = 1'b0;
        end else if (skipping) begin
            if (eop) begin
                skipping = 1'b0;
            end
        end else begin
            case (parse_ph)
                PH_ID1, PH_ID2, PH_ID3, PH_ID4: begin
                    parse_ph = phase_t'(parse_ph + 4'd1);
                end
                PH_ATTR_ID: begin
                    parse_ph = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    cur_len  = {8'd0, b};
                    parse_ph = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    lim = sel_msg ? msg_lim : title_lim;
                    cur_len = {b, cur_len[7:0]};
                    if (cur_len > lim) begin
                        add_result(KIND_ERROR, 0, (cur_len > 16'd255) ? 8'hFF : cur_len[7:0]);
                        restart_parse(eop);
                    end else begin
                        if (!sel_msg) begin
                            tsize = cur_len[7:0];
                            add_result(KIND_TITLE_LEN, 0, cur_len[7:0]);
                        end else begin
                            add_result(KIND_MSG_LEN, 0, cur_len[7:0]);
                        end
                        rcvd = 16'd0;
                        if (cur_len == 16'd0) begin
                            close_attribute(eop);
                        end else begin
                            parse_ph = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    add_result(KIND_WRITE, (sel_msg ? int'(tsize) : 0) + int'(rcvd), b);
                    rcvd = rcvd + 16'd1;
                    if (rcvd == cur_len) begin
                        close_attribute(eop);
                    end
                end
                default: begin
                    parse_ph = PH_ID1;
                end
            endcase
        end
        if (step_results.size() > 0) begin
            step_results[step_results.size() - 1].last = 1'b1;
        end
        foreach (step_results[i]) begin
            expected_results.push_back(step_results[i]);
        end
    endtask

    always @(posedge aclk) begin : p_drive
        in_item_t nxt;
        bit       busy;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                predict_byte(s_tuser, s_tdata, s_tlast);
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.act;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.eop;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : p_monitor
        exp_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, kind", int'(m_tuser), -1);
            end else begin
                e = expected_results.pop_front();
                if (m_tuser !== e.kind) begin
                    report_mismatch("kind", int'(m_tuser), int'(e.kind));
                end
                if (m_tdata[7:0] !== e.addr) begin
                    report_mismatch("address", int'(m_tdata[7:0]), int'(e.addr));
                end
                if (m_tdata[15:8] !== e.value) begin
                    report_mismatch("value", int'(m_tdata[15:8]), int'(e.value));
                end
                if (m_tlast !== e.last) begin
                    report_mismatch("last", int'(m_tlast), int'(e.last));
                end
            end
            results_seen++;
        end
    end

    task automatic push_item(input bit act, input bit [7:0] data, input bit eop);
        in_item_t it;
        it.act  = act;
        it.data = data;
        it.eop  = eop;
        pending_bytes.push_back(it);
        pushed++;
    endtask

    // A well-formed response, optionally cut short, with random content and packet marks.
    task automatic push_response(input bit [15:0] t_len, input bit [15:0] m_len, input int cut);
        bit [7:0] bq[$];
        int       n;
        bit       eop;
        repeat (6) bq.push_back(8'($urandom));
        bq.push_back(t_len[7:0]);
        bq.push_back(t_len[15:8]);
        if (t_len <= title_lim) begin
            repeat (t_len) bq.push_back(8'($urandom));
            bq.push_back(8'($urandom));
            bq.push_back(m_len[7:0]);
            bq.push_back(m_len[15:8]);
            if (m_len <= msg_lim) begin
                repeat (m_len) bq.push_back(8'($urandom));
            end
        end
        n = (cut > 0 && cut < bq.size()) ? cut : bq.size();
        eop = 1'b0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 2) begin
                push_item(1'b1, 8'($urandom), 1'($urandom_range(0, 1)));
            end
            eop = (i == n - 1) ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 4);
            push_item(1'b0, bq[i], eop);
        end
        if (!eop) begin
            repeat ($urandom_range(0, 2)) push_item(1'b0, 8'($urandom), 1'b0);
            push_item(1'b0, 8'($urandom), 1'b1);
        end
    endtask

    function automatic bit [15:0] pick_len(input bit [7:0] lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 16'd0;
        end
        if (r < 18 && lim <= 8'd20) begin
            return {8'd0, lim};
        end
        if (r < 26) begin
            return {8'd0, lim} + 16'd1;
        end
        if (r < 32) begin
            return {8'($urandom_range(1, 255)), 8'($urandom)};
        end
        return 16'($urandom_range(0, (lim < 8'd6) ? int'(lim) : 6));
    endfunction

    task automatic random_traffic(input int budget);
        int start;
        int r;
        start = pushed;
        while (pushed - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 82) begin
                push_response(pick_len(title_lim), pick_len(msg_lim), 0);
            end else if (r < 91) begin
                push_response(pick_len(title_lim), pick_len(msg_lim), $urandom_range(1, 12));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    push_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [7:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_TITLE_LIMIT) begin
            title_lim = val;
        end else begin
            msg_lim = val;
        end
    endtask

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // A new-notification event with nothing in progress.
        push_item(1'b1, 8'hA5, 1'b0);
        // Zero-length title and message: completion comes from the length byte, the
        // rest of the packet is then dropped.
        push_item(1'b0, 8'h00, 1'b0);
        repeat (4) push_item(1'b0, 8'hFF, 1'b0);
        push_item(1'b0, 8'h01, 1'b0);
        push_item(1'b0, 8'h00, 1'b0);
        push_item(1'b0, 8'h00, 1'b0);
        push_item(1'b0, 8'h03, 1'b0);
        push_item(1'b0, 8'h00, 1'b0);
        push_item(1'b0, 8'h00, 1'b0);
        push_item(1'b0, 8'h5A, 1'b0);
        push_item(1'b0, 8'hFF, 1'b1);
        // Title length with a nonzero high byte, aborted on the final byte of the packet.
        push_item(1'b0, 8'hFF, 1'b0);
        repeat (4) push_item(1'b0, 8'h00, 1'b0);
        push_item(1'b0, 8'h01, 1'b0);
        push_item(1'b0, 8'h00, 1'b0);
        push_item(1'b0, 8'h01, 1'b1);
        random_traffic(14);
        wait_idle();

        write_reg(REG_TITLE_LIMIT, 8'd0);
        write_reg(REG_MESSAGE_LIMIT, 8'd255);
        idle_pct = 71;
        random_traffic(14);
        wait_idle();

        write_reg(REG_TITLE_LIMIT, 8'd255);
        write_reg(REG_MESSAGE_LIMIT, 8'd0);
        idle_pct  = 0;
        stall_pct = 71;
        random_traffic(14);
        wait_idle();

        // The receiver holds off long enough to back up the input.
        write_reg(REG_MESSAGE_LIMIT, 8'd255);
        idle_pct  = 9;
        stall_pct = 9;
        hold_left = 80;
        random_traffic(14);
        wait_idle();

        write_reg(REG_TITLE_LIMIT, 8'($urandom_range(1, 254)));
        write_reg(REG_MESSAGE_LIMIT, 8'($urandom_range(1, 254)));
        idle_pct  = 0;
        stall_pct = 0;
        random_traffic(14);
        wait_idle();

        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
